// File: rtl/assert_macros.svh
// Assertion macros for the axis refinement merge datapath RTL.
// Depends on nothing; the checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked property, disabled while the reset is high.
`define ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property with no reset qualifier.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// File: rtl/arm_pkg.sv
// Types, widths and codes for the axis refinement merge block.
// Used by the interfaces, the controller, the datapath and the top level.
package arm_pkg;

  localparam int REF_DEPTH = 32;
  localparam int COORD_W   = 32;
  localparam int CNT_W     = 6;
  localparam int SLOT_W    = 5;
  localparam int IDX_W     = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;

  localparam logic signed [COORD_W-1:0] Q_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] Q_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_CELL  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_WALK,
    S_FINAL
  } state_t;

  typedef struct packed {
    logic write_table;
    logic load_cell;
    logic emit_start;
    logic step_walk;
    logic emit_final;
  } arm_cmd_t;

  typedef struct packed {
    logic out_free;
    logic walk_hit;
    logic cell_last;
  } arm_sts_t;

  // Saturate a difference that carries one extra bit.
  function automatic logic signed [COORD_W-1:0] sat_diff(input logic signed [COORD_W:0] v);
    logic signed [COORD_W-1:0] r;
    if (v[COORD_W] != v[COORD_W-1]) begin
      r = v[COORD_W] ? Q_MIN : Q_MAX;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/arm_if.sv
// Handshake channels of the axis refinement merge block: input items,
// result items and the count register write. Depends on arm_pkg.
interface arm_item_if;
  import arm_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [SLOT_W-1:0]         slot;
  logic signed [COORD_W-1:0] coordinate;
  logic signed [COORD_W-1:0] cell_size;
  logic                      last_cell;

  modport source (output valid, action, slot, coordinate, cell_size, last_cell,
                  input ready);
  modport sink (input valid, action, slot, coordinate, cell_size, last_cell,
                output ready);
endinterface

interface arm_result_if;
  import arm_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] new_size;
  logic                      bad_size;
  logic                      last;

  modport source (output valid, new_size, bad_size, last, input ready);
  modport sink (input valid, new_size, bad_size, last, output ready);
endinterface

interface arm_cfg_if;
  import arm_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: rtl/arm_ctrl.sv
// Sequencer of the axis refinement merge block: takes items and steps the
// datapath through start, table walk and final size. Depends on arm_pkg.
module arm_ctrl
  import arm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  input  logic     item_action,
  output logic     item_ready,
  input  arm_sts_t sts,
  output arm_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          if (item_action == ACT_CELL) begin
            cmd.load_cell = 1'b1;
            state_next    = S_START;
          end else begin
            cmd.write_table = 1'b1;
          end
        end
      end
      S_START: begin
        if (sts.out_free) begin
          cmd.emit_start = 1'b1;
          state_next     = S_WALK;
        end
      end
      S_WALK: begin
        if (sts.walk_hit) begin
          cmd.step_walk = sts.out_free;
        end else begin
          state_next = sts.cell_last ? S_FINAL : S_IDLE;
        end
      end
      S_FINAL: begin
        if (sts.out_free) begin
          cmd.emit_final = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/arm_dpath.sv
// Datapath of the axis refinement merge block: refinement table, walk
// position, distance arithmetic and the output register. Depends on arm_pkg.
`include "assert_macros.svh"

module arm_dpath
  import arm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  arm_cmd_t                  cmd,
  output arm_sts_t                  sts,
  input  logic [SLOT_W-1:0]         item_slot,
  input  logic signed [COORD_W-1:0] item_coordinate,
  input  logic signed [COORD_W-1:0] item_cell_size,
  input  logic                      item_last_cell,
  input  logic                      cfg_valid,
  input  logic [CNT_W-1:0]          cfg_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [COORD_W-1:0] out_new_size,
  output logic                      out_bad_size,
  output logic                      out_last
);

  logic signed [COORD_W-1:0] ref_table [REF_DEPTH];
  logic [CNT_W-1:0]          ref_count;
  logic [CNT_W-1:0]          pos;
  logic signed [COORD_W-1:0] prev_coord;
  logic                      have_prev;
  logic signed [COORD_W-1:0] cell_start;
  logic signed [COORD_W-1:0] cell_size;
  logic signed [COORD_W:0]   limit;
  logic                      cell_last;

  logic [CNT_W-1:0]          active_count;
  logic                      pos_ok;
  logic signed [COORD_W-1:0] entry;
  logic signed [COORD_W:0]   start_diff;
  logic signed [COORD_W:0]   entry_diff;
  logic signed [COORD_W+1:0] fin;
  logic                      fin_pos;
  logic signed [COORD_W-1:0] fin_size;
  logic                      push;
  logic [CNT_W-1:0]          slot_ext;

  assign active_count = (ref_count > CNT_W'(REF_DEPTH)) ? CNT_W'(REF_DEPTH) : ref_count;
  assign pos_ok       = pos < active_count;
  assign entry        = ref_table[pos[IDX_W-1:0]];
  assign slot_ext     = CNT_W'(item_slot);

  assign start_diff = {cell_start[COORD_W-1], cell_start} - {prev_coord[COORD_W-1], prev_coord};
  assign entry_diff = {entry[COORD_W-1], entry} - {prev_coord[COORD_W-1], prev_coord};

  // Final size: old last size, corrected by the last emitted coordinate when
  // any table entry was consumed on this axis.
  always_comb begin
    fin = {{2{cell_size[COORD_W-1]}}, cell_size};
    if (pos != '0) begin
      fin = fin + {{2{cell_start[COORD_W-1]}}, cell_start}
                - {{2{prev_coord[COORD_W-1]}}, prev_coord};
    end
    fin_pos = !fin[COORD_W+1] && (fin != '0);
    if (fin[COORD_W+1:COORD_W-1] != 3'b000) begin
      fin_size = Q_MAX;
    end else begin
      fin_size = fin[COORD_W-1:0];
    end
  end

  assign sts.out_free  = !out_valid || out_ready;
  assign sts.walk_hit  = pos_ok && ($signed({entry[COORD_W-1], entry}) < limit);
  assign sts.cell_last = cell_last;

  assign push = (cmd.emit_start && have_prev) || cmd.step_walk || cmd.emit_final;

  always_ff @(posedge clk) begin
    if (cmd.write_table && (slot_ext < CNT_W'(REF_DEPTH))) begin
      ref_table[slot_ext[IDX_W-1:0]] <= item_coordinate;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_cell) begin
      cell_start <= item_coordinate;
      cell_size  <= item_cell_size;
      cell_last  <= item_last_cell;
      limit      <= {item_coordinate[COORD_W-1], item_coordinate}
                  + {item_cell_size[COORD_W-1], item_cell_size};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_count  <= '0;
      pos        <= '0;
      prev_coord <= '0;
      have_prev  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        ref_count <= cfg_data;
      end
      if (cmd.emit_start) begin
        prev_coord <= cell_start;
        have_prev  <= 1'b1;
        // Skip a table entry that coincides with the cell start.
        if (pos_ok && (entry == cell_start)) begin
          pos <= pos + 1'b1;
        end
      end else if (cmd.step_walk) begin
        prev_coord <= entry;
        pos        <= pos + 1'b1;
      end else if (cmd.emit_final) begin
        prev_coord <= '0;
        have_prev  <= 1'b0;
        pos        <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_start) begin
      out_new_size <= sat_diff(start_diff);
      out_bad_size <= 1'b0;
      out_last     <= 1'b0;
    end else if (cmd.step_walk) begin
      out_new_size <= sat_diff(entry_diff);
      out_bad_size <= 1'b0;
      out_last     <= 1'b0;
    end else if (cmd.emit_final) begin
      out_new_size <= fin_pos ? fin_size : '0;
      out_bad_size <= !fin_pos;
      out_last     <= 1'b1;
    end
  end

  `ASSERT_RST(a_pos_in_range, clk, rst, pos <= CNT_W'(REF_DEPTH), "walk position beyond table")
  `ASSERT_RST(a_no_overwrite, clk, rst, !(push && out_valid && !out_ready), "result overwritten")
  `ASSERT_RST(a_axis_cleared, clk, rst, cmd.emit_final |=> (pos == '0 && !have_prev), "axis not cleared")
  `ASSERT_RST(a_pos_needs_prev, clk, rst, !have_prev |-> (pos == '0), "table used before start")

endmodule

// File: rtl/axis_refinement_merge_core.sv
// Top level of the axis refinement merge block: ties the sequencer to the
// datapath. Depends on arm_pkg, the arm interfaces, arm_ctrl and arm_dpath.
//
// Usage: item carries table writes (action 0: coordinate into slot) and old
// cells (action 1: start coordinate and size, last_cell on the axis end).
// Load the table and write ref_count on cfg before the cells of an axis;
// cfg is always ready and must only be written while the block is idle.
// result carries refined cell sizes in order, the final one with last set
// and bad_size set when that size is zero or negative.
// A cell passes through the start and walk states, one walk step per table
// entry it consumes, and the final state when it is the last cell. While the
// output is free, the walk reads one table entry per cycle from the register
// file and one result leaves per cycle through a single output register.
// A cell that follows another on the same axis has its first result
// registered from the start state once the output is free; on the first
// cell of an axis the start state emits none; it comes from the walk or final.
// Reset clears the walk position, the count and the output valid flag; the
// table contents are kept undefined until written.
// When the receiver stalls, the walk holds at its current entry until the
// output register is taken, and no new item is accepted meanwhile.
module axis_refinement_merge_core
  import arm_pkg::*;
(
  input logic   clk,
  input logic   rst,
  arm_item_if.sink     item,
  arm_result_if.source result,
  arm_cfg_if.sink      cfg
);

  arm_cmd_t cmd;
  arm_sts_t sts;

  assign cfg.ready = 1'b1;

  arm_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item.valid),
    .item_action (item.action),
    .item_ready  (item.ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  arm_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .item_slot       (item.slot),
    .item_coordinate (item.coordinate),
    .item_cell_size  (item.cell_size),
    .item_last_cell  (item.last_cell),
    .cfg_valid       (cfg.valid),
    .cfg_data        (cfg.data),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .out_new_size    (result.new_size),
    .out_bad_size    (result.bad_size),
    .out_last        (result.last)
  );

endmodule

// File: tb/tb_axis_refinement_merge_core.sv
`timescale 1ns / 100ps
// Testbench for axis_refinement_merge_core: loads refinement tables, sends old cells
// and checks every refined size against a transaction-level predictor.
// Depends on arm_pkg, the arm channel interfaces and the core RTL.
module tb_axis_refinement_merge_core;
  import arm_pkg::*;

  localparam longint Q16_HI = 64'sd2147483647;
  localparam longint Q16_LO = -64'sd2147483648;
  localparam int ITEM_TARGET = 450;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    action_t                   action;
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] coordinate;
    logic signed [COORD_W-1:0] cell_size;
    logic                      last_cell;
  } axis_req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] new_size;
    logic                      bad_size;
    logic                      last;
  } refined_size_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  arm_item_if   item_bus ();
  arm_result_if size_bus ();
  arm_cfg_if    count_bus ();

  axis_refinement_merge_core DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (size_bus),
    .cfg    (count_bus)
  );

  axis_req_t     pending_items [$];
  refined_size_t expected_sizes [$];
  int items_queued = 0;
  int items_taken = 0;
  int size_errors = 0;
  int idle_cycles = 0;
  int tx_wait = 0;
  int rx_hold = 0;
  bit item_fired = 1'b0;
  bit cfg_fired = 1'b0;
  bit calm_run = 1'b0;

  // Predictor copy of the block state.
  logic signed [COORD_W-1:0] refine_coords [REF_DEPTH];
  logic [CNT_W-1:0]          count_reg;
  int                        walk_pos;
  longint                    last_emitted;
  bit                        emitted_any;
  longint                    axis_last_start;

  // Slots that the stimulus has already queued a write for.
  bit gen_written [REF_DEPTH];

  initial begin : clock_gen
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm_run || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp_q16(input longint v);
    if (v > Q16_HI) return 32'sh7FFFFFFF;
    if (v < Q16_LO) return 32'sh80000000;
    return v[COORD_W-1:0];
  endfunction

  task automatic note_size(input longint v, input logic bad, input logic fin_flag);
    refined_size_t s;
    s.new_size = clamp_q16(v);
    s.bad_size = bad;
    s.last = fin_flag;
    expected_sizes.insert(expected_sizes.size(), s);
  endtask

  task automatic emit_coord(input longint c);
    if (emitted_any) note_size(c - last_emitted, 1'b0, 1'b0);
    last_emitted = c;
    emitted_any = 1'b1;
  endtask

  task automatic predict_sizes(input axis_req_t it);
    int     active;
    longint start;
    longint reach;
    longint fin;
    if (it.action == ACT_WRITE) begin
      if (it.slot < REF_DEPTH) refine_coords[it.slot] = it.coordinate;
      return;
    end
    active = (count_reg > REF_DEPTH) ? REF_DEPTH : int'(count_reg);
    start = $signed(it.coordinate);
    axis_last_start = start;
    emit_coord(start);
    // A table entry sitting exactly on the cell start is consumed without emitting.
    if (walk_pos < active && longint'(refine_coords[walk_pos]) == start) walk_pos++;
    reach = start + longint'($signed(it.cell_size));
    while (walk_pos < active && longint'(refine_coords[walk_pos]) < reach) begin
      emit_coord(longint'(refine_coords[walk_pos]));
      walk_pos++;
    end
    if (it.last_cell) begin
      fin = $signed(it.cell_size);
      if (walk_pos > 0) fin += axis_last_start - last_emitted;
      if (fin > 0) begin
        note_size(fin, 1'b0, 1'b1);
      end else begin
        note_size(0, 1'b1, 1'b1);
      end
      walk_pos = 0;
      last_emitted = 0;
      emitted_any = 1'b0;
    end
  endtask

  task automatic put_coord(input int slot, input longint v);
    axis_req_t req;
    req.action = ACT_WRITE;
    req.slot = slot[SLOT_W-1:0];
    req.coordinate = v[COORD_W-1:0];
    req.cell_size = $urandom();
    req.last_cell = 1'($urandom_range(0, 1));
    pending_items.insert(pending_items.size(), req);
    items_queued++;
    gen_written[slot] = 1'b1;
  endtask

  task automatic put_cell(input longint start, input longint size, input bit lst);
    axis_req_t req;
    req.action = ACT_CELL;
    req.slot = SLOT_W'($urandom_range(0, REF_DEPTH - 1));
    req.coordinate = start[COORD_W-1:0];
    req.cell_size = size[COORD_W-1:0];
    req.last_cell = lst;
    pending_items.insert(pending_items.size(), req);
    items_queued++;
  endtask

  // Waits until every queued item is taken and every predicted size has come back.
  task automatic settle(input int extra);
    while (items_taken != items_queued || expected_sizes.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_count(input int v);
    settle(SETTLE_CYCLES);
    count_bus.valid <= 1'b1;
    count_bus.data <= v[CNT_W-1:0];
    do @(negedge clk); while (!cfg_fired);
    count_bus.valid <= 1'b0;
  endtask

  always @(negedge clk) begin : drive_items
    axis_req_t nxt;
    if (rst) begin
      item_bus.valid <= 1'b0;
      tx_wait <= 0;
    end else if (!item_bus.valid || item_fired) begin
      if (tx_wait > 0) begin
        item_bus.valid <= 1'b0;
        tx_wait <= tx_wait - 1;
      end else if (pending_items.size() > 0) begin
        nxt = pending_items.pop_front();
        item_bus.valid <= 1'b1;
        item_bus.action <= nxt.action;
        item_bus.slot <= nxt.slot;
        item_bus.coordinate <= nxt.coordinate;
        item_bus.cell_size <= nxt.cell_size;
        item_bus.last_cell <= nxt.last_cell;
        tx_wait <= pick_gap();
      end else begin
        item_bus.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : drive_ready
    if (rst) begin
      size_bus.ready <= 1'b0;
      rx_hold <= 0;
    end else if (rx_hold > 0) begin
      size_bus.ready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      size_bus.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) rx_hold <= pick_gap();
    end
  end

  always @(posedge clk) begin : watch_ports
    axis_req_t     seen;
    refined_size_t got;
    refined_size_t want;
    if (rst) begin
      item_fired <= 1'b0;
      cfg_fired <= 1'b0;
      count_reg = '0;
      walk_pos = 0;
      last_emitted = 0;
      emitted_any = 1'b0;
      axis_last_start = 0;
      idle_cycles = 0;
    end else begin
      item_fired <= item_bus.valid && item_bus.ready;
      cfg_fired <= count_bus.valid && count_bus.ready;
      if ($urandom_range(0, 63) == 0) calm_run <= !calm_run;
      // Results are checked before this edge's input transfer is predicted.
      if (size_bus.valid && size_bus.ready) begin
        got.new_size = size_bus.new_size;
        got.bad_size = size_bus.bad_size;
        got.last = size_bus.last;
        if (expected_sizes.size() == 0) begin
          $display("%0t: refined size with nothing expected: size %h bad %b last %b",
                   $time, got.new_size, got.bad_size, got.last);
          size_errors++;
        end else begin
          want = expected_sizes.pop_front();
          if (got.new_size !== want.new_size || got.bad_size !== want.bad_size ||
              got.last !== want.last) begin
            $display("%0t: expected size %h bad %b last %b, got size %h bad %b last %b",
                     $time, want.new_size, want.bad_size, want.last,
                     got.new_size, got.bad_size, got.last);
            size_errors++;
          end
        end
      end
      if (count_bus.valid && count_bus.ready) count_reg = count_bus.data;
      if (item_bus.valid && item_bus.ready) begin
        seen.action = action_t'(item_bus.action);
        seen.slot = item_bus.slot;
        seen.coordinate = item_bus.coordinate;
        seen.cell_size = item_bus.cell_size;
        seen.last_cell = item_bus.last_cell;
        items_taken++;
        predict_sizes(seen);
      end
      if ((item_bus.valid && item_bus.ready) || (size_bus.valid && size_bus.ready) ||
          (count_bus.valid && count_bus.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin : run_test
    int     cnt;
    int     n;
    int     m;
    int     r;
    int     j;
    longint bound [7];
    longint tab [REF_DEPTH];
    longint x;
    longint span;
    item_bus.valid = 1'b0;
    item_bus.action = 1'b0;
    item_bus.slot = '0;
    item_bus.coordinate = '0;
    item_bus.cell_size = '0;
    item_bus.last_cell = 1'b0;
    size_bus.ready = 1'b0;
    count_bus.valid = 1'b0;
    count_bus.data = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Empty table: one- and two-cell axes, bad final sizes and saturated distances.
    put_cell(0, 32'h10000, 1'b1);
    put_cell(5, 0, 1'b1);
    put_cell(Q16_LO, Q16_LO, 1'b1);
    put_cell(Q16_HI, Q16_HI, 1'b1);
    put_cell(Q16_HI, 1, 1'b0);
    put_cell(Q16_LO, 5, 1'b1);
    put_cell(Q16_LO, 1, 1'b0);
    put_cell(Q16_HI, 1, 1'b1);

    // An entry below the cell start drives the final size past the top.
    write_count(1);
    put_coord(0, Q16_LO);
    put_cell(0, Q16_HI, 1'b1);

    // Entry on a cell start is skipped; the count drops to the walk position mid axis.
    write_count(3);
    put_coord(0, 32'h10000);
    put_coord(1, 32'h18000);
    put_coord(2, 32'h30000);
    put_cell(32'h10000, 32'h10000, 1'b0);
    put_cell(32'h20000, 32'h10000, 1'b1);
    put_cell(32'h10000, 32'h8000, 1'b0);
    write_count(1);
    put_cell(32'h18000, 32'h10000, 1'b1);
    put_coord(REF_DEPTH - 1, -1);

    while (items_queued < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 65) cnt = $urandom_range(0, 8);
      else if (r < 82) cnt = $urandom_range(9, 31);
      else if (r < 91) cnt = REF_DEPTH;
      else cnt = $urandom_range(33, 63);
      write_count(cnt);
      n = (cnt > REF_DEPTH) ? REF_DEPTH : cnt;
      m = $urandom_range(1, 6);
      bound[0] = longint'($urandom_range(0, 32'h7FFFFFFF)) - 64'sd1073741824;
      for (int i = 1; i <= m; i++) begin
        if ($urandom_range(0, 3) == 0) bound[i] = bound[i-1] + $urandom_range(1, 16);
        else bound[i] = bound[i-1] + $urandom_range(32'h100, 32'h80000);
      end
      span = bound[m] - bound[0];
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 3) == 0) x = bound[$urandom_range(0, m - 1)];
        else x = bound[0] - 64'sd4096 + longint'($urandom_range(0, span + 8192));
        j = i;
        // Most tables are sorted; an occasional entry is left out of order.
        if ($urandom_range(0, 9) != 0) begin
          while (j > 0 && tab[j-1] > x) begin
            tab[j] = tab[j-1];
            j--;
          end
        end
        tab[j] = x;
      end
      for (int i = 0; i < n; i++) begin
        put_coord(i, tab[i]);
        if ($urandom_range(0, 15) == 0)
          put_coord($urandom_range(0, REF_DEPTH - 1), longint'($signed($urandom())));
      end
      for (int i = 0; i < m; i++) begin
        if (i > 0 && $urandom_range(0, 9) == 0) begin
          j = 0;
          while (j < REF_DEPTH && gen_written[j]) j++;
          write_count((j == REF_DEPTH) ? $urandom_range(0, 63) : $urandom_range(0, j));
        end
        put_cell(bound[i], bound[i+1] - bound[i], (i == m - 1) && ($urandom_range(0, 9) != 0));
      end
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(2, 6)) begin
          if ($urandom_range(0, 1) == 0)
            put_coord($urandom_range(0, REF_DEPTH - 1), longint'($signed($urandom())));
          else
            put_cell(longint'($signed($urandom())), longint'($signed($urandom())),
                     1'($urandom_range(0, 1)));
        end
      end
    end

    settle(20);
    if (size_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
